>>> design/fat12_cluster_table_engine_defines.svh
// Assertion macros shared by the FAT12 cluster table engine.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef FAT12_CLUSTER_TABLE_ENGINE_DEFINES_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FAT12_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FAT12_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fat12_pkg.sv
// Shared types and constants of the FAT12 cluster table engine.
// No dependencies.
package fat12_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 14;
  localparam logic [LEN_W-1:0] TBL_LEN_MAX = LEN_W'(TABLE_DEPTH);

  // Command codes.
  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_GET   = 3'd2,
    CMD_SET   = 3'd3,
    CMD_FIND  = 3'd4,
    CMD_ALLOC = 3'd5,
    CMD_FREE  = 3'd6,
    CMD_NOP   = 3'd7
  } cmd_t;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_PAST = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TABLE_BYTES  = 2'd0;
  localparam logic [1:0] CFG_TOTAL_SECT   = 2'd1;
  localparam logic [1:0] CFG_FIRST_DATA   = 2'd2;
  localparam logic [1:0] CFG_CLUSTER_SECT = 2'd3;

  // Entry values.
  localparam logic [11:0] CHAIN_END    = 12'hFFF;
  localparam logic [11:0] RESERVED_LO  = 12'hFF0;
  localparam logic [11:0] CLUSTER_CAP  = 12'hFEF;
  localparam logic [11:0] FIRST_DATA_CL = 12'd2;
  localparam logic [31:0] QUOT_SAT     = 32'hFEE;

  // Divider width.
  localparam int DIV_W   = 32;
  localparam int DIV_CNT = $clog2(DIV_W);

endpackage

>>> design/fat12_ifs.sv
// Handshake interfaces of the FAT12 cluster table engine.
// Depends on nothing but plain logic types.
interface fat12_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [12:0] byte_address;
  logic [7:0]  byte_in;
  logic [11:0] cluster;
  logic [11:0] entry_value;
  logic [11:0] chain_length;
  modport source(output valid, cmd, byte_address, byte_in, cluster, entry_value,
                 chain_length, input ready);
  modport sink(input valid, cmd, byte_address, byte_in, cluster, entry_value,
               chain_length, output ready);
endinterface

interface fat12_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cluster_out;
  logic [7:0]  byte_out;
  logic [1:0]  status;
  modport source(output valid, cluster_out, byte_out, status, input ready);
  modport sink(input valid, cluster_out, byte_out, status, output ready);
endinterface

interface fat12_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/fat12_ram.sv
// Single-port byte RAM holding the allocation table.
// Generic; read data is registered.
module fat12_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // One access per cycle: write or registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> design/fat12_div.sv
// Bit-serial divider for the cluster limit: data sectors over cluster size.
// Uses fat12_pkg for widths.
module fat12_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fat12_pkg::DIV_W-1:0] dividend,
  input  logic [7:0]                 divisor,
  output logic [fat12_pkg::DIV_W-1:0] quotient,
  output logic                       done
);

  logic [fat12_pkg::DIV_W-1:0]   quo_r;
  logic [7:0]                    rem_r;
  logic [fat12_pkg::DIV_CNT-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [8:0]                    shift;
  logic                          fits;

  // One quotient bit per cycle.
  assign shift = {rem_r, quo_r[fat12_pkg::DIV_W-1]};
  assign fits  = shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? 8'(shift - {1'b0, divisor}) : shift[7:0];
        quo_r <= {quo_r[fat12_pkg::DIV_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == fat12_pkg::DIV_CNT'(fat12_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> design/fat12_cluster_table_engine.sv
// Top level of the FAT12 cluster table engine: command sequencer around the
// table RAM and the limit divider. Uses fat12_pkg, fat12_ifs, fat12_ram, fat12_div.
//
// Usage:
//  in_if carries one command request; it is taken when valid and ready are high.
//  Ready is high only while the sequencer is idle: one request at a time.
//  out_if returns exactly one result request per command from an output
//  register; a new command is taken while that result still waits.
//  cfg_if writes register index/data; ready is always high, write only when idle.
//  Get reads an entry's two bytes and set also writes both back; an entry past
//  the table is neither read nor written. Find: a limit division, then a scan
//  entry by entry. Alloc: the same division and scan, plus a link write to the
//  previous entry and an end mark for each entry found (only the mark for the
//  first); a roll back or free walks the chain and clears each entry.
//  The single RAM port (one byte per cycle, two bytes per entry) sets the rate.
//  Reset loads the default geometry; the table contents are undefined until
//  loaded, and no clearing pass runs.
//  When the receiver stalls, one finished result waits in the output register
//  and a second one waits in the sequencer, which then holds off new requests.
`include "fat12_cluster_table_engine_defines.svh"

module fat12_cluster_table_engine (
  input  logic clk,
  input  logic rst_n,
  fat12_cfg_if.sink   cfg_if,
  fat12_in_if.sink    in_if,
  fat12_out_if.source out_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RDB, S_DIV, S_SCAN, S_FCHK,
    S_G0, S_G1, S_G2, S_W0, S_W1, S_NEXT, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    PH_GET, PH_SRCH, PH_LINK, PH_MARK, PH_FREE
  } phase_t;

  // Configuration registers.
  logic [fat12_pkg::LEN_W-1:0] tbl_bytes_r;
  logic [31:0] tot_sec_r;
  logic [15:0] fds_r;
  logic [7:0]  csec_r;

  // Request fields.
  fat12_pkg::cmd_t cmd_r;
  logic [12:0] addr_r;
  logic [7:0]  bin_r;
  logic [11:0] cl_r;
  logic [11:0] val_r;
  logic [11:0] n_r;

  // Work registers.
  state_t      state_r;
  phase_t      ph_r;
  logic [11:0] scan_r, lim_r, prev_r, first_r, found_r, walk_r, cnt_r;
  logic [11:0] ent_c_r, wval_r, ent_val_r;
  logic        do_wr_r, past_r;
  logic [7:0]  b0_r, b1_r;

  // Result and output registers.
  logic [11:0] res_cl_r;
  logic [7:0]  res_byte_r;
  logic [1:0]  res_st_r;
  logic        out_valid_r;
  logic [11:0] out_cl_r;
  logic [7:0]  out_byte_r;
  logic [1:0]  out_st_r;

  logic [fat12_pkg::LEN_W-1:0]  tbl_len;
  logic [12:0]                  off;
  logic                         ent_past;
  logic                         addr_ok;
  logic                         ram_en, ram_we;
  logic [fat12_pkg::ADDR_W-1:0] ram_addr;
  logic [7:0]                   ram_wdata, ram_rdata;
  logic [7:0]                   m0, m1;
  logic [11:0]                  rd_val;
  logic                         div_start, div_done;
  logic [31:0]                  quot;
  logic [11:0]                  lim_calc;
  logic                         out_free;

  // Table length and entry addressing.
  assign tbl_len  = (tbl_bytes_r < fat12_pkg::TBL_LEN_MAX) ? tbl_bytes_r
                                                           : fat12_pkg::TBL_LEN_MAX;
  assign off      = {1'b0, ent_c_r} + {2'b0, ent_c_r[11:1]};
  assign ent_past = ({1'b0, off} + 14'd1) >= tbl_len;
  assign addr_ok  = {1'b0, addr_r} < tbl_len;

  // Packed entry extraction and merge of a new value into the byte pair.
  assign rd_val = ent_c_r[0] ? {ram_rdata, b0_r[7:4]} : {ram_rdata[3:0], b0_r};
  assign m0     = ent_c_r[0] ? {wval_r[3:0], b0_r[3:0]} : wval_r[7:0];
  assign m1     = ent_c_r[0] ? wval_r[11:4] : {b1_r[7:4], wval_r[11:8]};

  // Cluster limit from the divider quotient, capped.
  assign lim_calc = (quot >= fat12_pkg::QUOT_SAT) ? fat12_pkg::CLUSTER_CAP
                                                  : 12'(quot[11:0] + fat12_pkg::FIRST_DATA_CL);

  assign div_start = (state_r == S_DISP) &&
                     ((cmd_r == fat12_pkg::CMD_FIND) ||
                      ((cmd_r == fat12_pkg::CMD_ALLOC) && (n_r != 12'd0)));

  assign out_free = !out_valid_r || out_if.ready;

  // RAM port control; accesses are strictly sequenced, so no two overlap.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = off[fat12_pkg::ADDR_W-1:0];
    ram_wdata = m0;
    unique case (state_r)
      S_DISP: begin
        ram_addr  = addr_r[fat12_pkg::ADDR_W-1:0];
        ram_wdata = bin_r;
        if ((cmd_r == fat12_pkg::CMD_LOAD || cmd_r == fat12_pkg::CMD_READ) && addr_ok) begin
          ram_en = 1'b1;
          ram_we = (cmd_r == fat12_pkg::CMD_LOAD);
        end
      end
      S_G0: ram_en = !ent_past;
      S_G1: begin
        ram_en   = 1'b1;
        ram_addr = fat12_pkg::ADDR_W'(off + 13'd1);
      end
      S_W0: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      S_W1: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = fat12_pkg::ADDR_W'(off + 13'd1);
        ram_wdata = m1;
      end
      default: ;
    endcase
  end

  fat12_ram #(.DEPTH(fat12_pkg::TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fat12_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tot_sec_r - {16'd0, fds_r}),
    .divisor  ((csec_r == 8'd0) ? 8'd1 : csec_r),
    .quotient (quot),
    .done     (div_done)
  );

  // Configuration writes.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_bytes_r <= 14'd4608;
      tot_sec_r   <= 32'd2880;
      fds_r       <= 16'd33;
      csec_r      <= 8'd1;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        fat12_pkg::CFG_TABLE_BYTES:  tbl_bytes_r <= cfg_if.data[fat12_pkg::LEN_W-1:0];
        fat12_pkg::CFG_TOTAL_SECT:   tot_sec_r   <= cfg_if.data;
        fat12_pkg::CFG_FIRST_DATA:   fds_r       <= cfg_if.data[15:0];
        fat12_pkg::CFG_CLUSTER_SECT: csec_r      <= cfg_if.data[7:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_r == S_IDLE);

  // Command sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A result taken while a new one is being loaded is handled in S_RESP.
      if (out_valid_r && out_if.ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            cmd_r   <= fat12_pkg::cmd_t'(in_if.cmd);
            addr_r  <= in_if.byte_address;
            bin_r   <= in_if.byte_in;
            cl_r    <= in_if.cluster;
            val_r   <= in_if.entry_value;
            n_r     <= in_if.chain_length;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          res_cl_r   <= '0;
          res_byte_r <= '0;
          res_st_r   <= fat12_pkg::ST_OK;
          prev_r     <= '0;
          first_r    <= '0;
          cnt_r      <= '0;
          state_r    <= S_RESP;
          unique case (cmd_r) inside
            fat12_pkg::CMD_LOAD: begin
              if (!addr_ok) begin
                res_st_r <= fat12_pkg::ST_PAST;
              end
            end
            fat12_pkg::CMD_READ: begin
              if (addr_ok) begin
                state_r <= S_RDB;
              end
            end
            fat12_pkg::CMD_GET, fat12_pkg::CMD_SET: begin
              ent_c_r <= cl_r;
              wval_r  <= val_r;
              do_wr_r <= (cmd_r == fat12_pkg::CMD_SET);
              ph_r    <= PH_GET;
              state_r <= S_G0;
            end
            fat12_pkg::CMD_FIND: state_r <= S_DIV;
            fat12_pkg::CMD_ALLOC: begin
              if (n_r != 12'd0) begin
                state_r <= S_DIV;
              end
            end
            fat12_pkg::CMD_FREE: begin
              walk_r  <= cl_r;
              state_r <= S_FCHK;
            end
            default: ;
          endcase
        end
        S_RDB: begin
          res_byte_r <= ram_rdata;
          state_r    <= S_RESP;
        end
        S_DIV: begin
          if (div_done) begin
            lim_r <= lim_calc;
            if (cmd_r == fat12_pkg::CMD_FIND && cl_r >= fat12_pkg::FIRST_DATA_CL) begin
              scan_r <= cl_r;
            end else begin
              scan_r <= fat12_pkg::FIRST_DATA_CL;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_r >= lim_r) begin
            res_cl_r <= '0;
            res_st_r <= fat12_pkg::ST_FULL;
            if (cmd_r == fat12_pkg::CMD_ALLOC && first_r != 12'd0) begin
              walk_r  <= first_r;
              state_r <= S_FCHK;
            end else begin
              state_r <= S_RESP;
            end
          end else begin
            ent_c_r <= scan_r;
            do_wr_r <= 1'b0;
            ph_r    <= PH_SRCH;
            state_r <= S_G0;
          end
        end
        S_FCHK: begin
          if (walk_r >= fat12_pkg::FIRST_DATA_CL && walk_r < fat12_pkg::RESERVED_LO) begin
            ent_c_r <= walk_r;
            wval_r  <= '0;
            do_wr_r <= 1'b1;
            ph_r    <= PH_FREE;
            state_r <= S_G0;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_G0: begin
          past_r <= ent_past;
          if (ent_past) begin
            ent_val_r <= fat12_pkg::CHAIN_END;
            state_r   <= S_NEXT;
          end else begin
            state_r <= S_G1;
          end
        end
        S_G1: begin
          b0_r    <= ram_rdata;
          state_r <= S_G2;
        end
        S_G2: begin
          b1_r      <= ram_rdata;
          ent_val_r <= rd_val;
          state_r   <= do_wr_r ? S_W0 : S_NEXT;
        end
        S_W0: state_r <= S_W1;
        S_W1: state_r <= S_NEXT;
        S_NEXT: begin
          unique case (ph_r)
            PH_GET: begin
              if (cmd_r == fat12_pkg::CMD_GET) begin
                res_cl_r <= ent_val_r;
              end else if (past_r) begin
                res_st_r <= fat12_pkg::ST_PAST;
              end
              state_r <= S_RESP;
            end
            PH_SRCH: begin
              if (ent_val_r == 12'd0) begin
                if (cmd_r == fat12_pkg::CMD_FIND) begin
                  res_cl_r <= scan_r;
                  state_r  <= S_RESP;
                end else begin
                  found_r <= scan_r;
                  do_wr_r <= 1'b1;
                  state_r <= S_G0;
                  if (prev_r != 12'd0) begin
                    ent_c_r <= prev_r;
                    wval_r  <= scan_r;
                    ph_r    <= PH_LINK;
                  end else begin
                    first_r <= scan_r;
                    ent_c_r <= scan_r;
                    wval_r  <= fat12_pkg::CHAIN_END;
                    ph_r    <= PH_MARK;
                  end
                end
              end else begin
                scan_r  <= scan_r + 12'd1;
                state_r <= S_SCAN;
              end
            end
            PH_LINK: begin
              ent_c_r <= found_r;
              wval_r  <= fat12_pkg::CHAIN_END;
              ph_r    <= PH_MARK;
              state_r <= S_G0;
            end
            PH_MARK: begin
              prev_r <= found_r;
              cnt_r  <= cnt_r + 12'd1;
              if (cnt_r + 12'd1 == n_r) begin
                res_cl_r <= first_r;
                state_r  <= S_RESP;
              end else begin
                scan_r  <= found_r + 12'd1;
                state_r <= S_SCAN;
              end
            end
            PH_FREE: begin
              walk_r  <= ent_val_r;
              state_r <= S_FCHK;
            end
            default: state_r <= S_RESP;
          endcase
        end
        S_RESP: begin
          if (out_free) begin
            out_cl_r    <= res_cl_r;
            out_byte_r  <= res_byte_r;
            out_st_r    <= res_st_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.cluster_out = out_cl_r;
  assign out_if.byte_out    = out_byte_r;
  assign out_if.status      = out_st_r;

  // Checks on the sequencer.
  `FAT12_ASSERT_NOW(a_wr_in_table, ram_en && ram_we, {1'b0, ram_addr} < tbl_len, "write past table")
  `FAT12_ASSERT_NOW(a_scan_floor, state_r == S_SCAN, scan_r >= fat12_pkg::FIRST_DATA_CL, "scan below 2")
  `FAT12_ASSERT_NEXT(a_accept_disp, in_if.valid && in_if.ready, state_r == S_DISP, "no dispatch")
  `FAT12_ASSERT_NOW(a_div_owner, div_done, state_r == S_DIV, "stray divider result")

endmodule
